// File: rtl/assert_macros.svh
// assertion helpers included by float32_exponential_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, ck, rstn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, ck, rstn, prop)
`define ASSERT_NEVER(lbl, ck, rstn, expr)
`endif

`endif

// File: rtl/f32exp_pkg.sv
`timescale 1ns / 1ps
package f32exp_pkg;

  localparam logic [31:0] EXP_HI_BITS = 32'h42B18D72;
  localparam logic [31:0] EXP_LO_BITS = 32'hC2CFF1B4;
  localparam logic [31:0] LOG2E_BITS  = 32'h3FB8AA3B;
  localparam logic [31:0] LN2_HI_BITS = 32'hBF317200;
  localparam logic [31:0] LN2_LO_BITS = 32'hB5BFBE8E;
  localparam logic [31:0] PC0_BITS    = 32'h3AB4A000;
  localparam logic [31:0] PC1_BITS    = 32'h3C092F6E;
  localparam logic [31:0] PC2_BITS    = 32'h3D2AADAD;
  localparam logic [31:0] PC3_BITS    = 32'h3E2AAA28;
  localparam logic [31:0] PC4_BITS    = 32'h3EFFFFFB;
  localparam logic [31:0] ONE_BITS    = 32'h3F800000;
  localparam logic [31:0] MAGIC_BITS  = 32'h4B400000;
  localparam logic [31:0] QNAN_BITS   = 32'h7FC00000;
  localparam logic [31:0] PINF_BITS   = 32'h7F800000;
  localparam logic [31:0] INF_MAG     = 32'h7F800000;

  localparam int NUM_POLY = 6;
  localparam logic [31:0] POLY_C [NUM_POLY] =
    '{PC1_BITS, PC2_BITS, PC3_BITS, PC4_BITS, ONE_BITS, ONE_BITS};

  typedef struct packed {
    logic              last;
    logic              spec;
    logic [31:0]       spec_y;
    logic [31:0]       x;
    logic signed [8:0] n;
    logic [31:0]       nf;
    logic [31:0]       r;
  } side_t;

endpackage

// File: rtl/f32exp_fma.sv
`timescale 1ns / 1ps
module f32exp_fma import f32exp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  side_t       side_i,
  output logic        vld_o,
  output logic [31:0] y_o,
  output side_t       side_o
);

  localparam int DEPTH = 7;

  function automatic logic [2:0] lz8(input logic [7:0] w);
    logic [2:0] c;
    c = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (w[i]) c = 3'(7 - i);
    end
    return c;
  endfunction

  logic [DEPTH-1:0] vld_r;
  side_t            side_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int i = 1; i < DEPTH; i++) side_r[i] <= side_r[i-1];
    end
  end

  // stage 1: unpack, multiply, alignment distance
  logic [7:0]         ea, eb, ec;
  logic [23:0]        ma, mb, mc;
  logic signed [10:0] ep, shf, fe_nxt;
  logic [6:0]         sh_nxt;

  assign ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
  assign eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
  assign ec = (c_i[30:23] == 8'd0) ? 8'd1 : c_i[30:23];
  assign ma = {a_i[30:23] != 8'd0, a_i[22:0]};
  assign mb = {b_i[30:23] != 8'd0, b_i[22:0]};
  assign mc = {c_i[30:23] != 8'd0, c_i[22:0]};
  assign ep = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd150;
  assign shf = 11'sd72 + ep - $signed({3'b0, ec});

  always_comb begin
    if (shf < 11'sd0) begin
      sh_nxt = 7'd0;
      fe_nxt = $signed({3'b0, ec}) - 11'sd224;
    end else begin
      sh_nxt = (shf > 11'sd127) ? 7'd127 : shf[6:0];
      fe_nxt = ep - 11'sd152;
    end
  end

  logic [47:0]        s1_mp_r;
  logic [23:0]        s1_mc_r;
  logic [6:0]         s1_sh_r;
  logic signed [10:0] s1_fe_r;
  logic               s1_sub_r, s1_sp_r, s1_sc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mp_r  <= ma * mb;
      s1_mc_r  <= mc;
      s1_sh_r  <= sh_nxt;
      s1_fe_r  <= fe_nxt;
      s1_sub_r <= a_i[31] ^ b_i[31] ^ c_i[31];
      s1_sp_r  <= a_i[31] ^ b_i[31];
      s1_sc_r  <= c_i[31];
    end
  end

  // stage 2: align addend, sticky into bit 0
  logic [99:0] full, cal, lost;
  assign full = {2'b0, s1_mc_r, 74'b0};
  assign cal  = full >> s1_sh_r;
  assign lost = full & ~({100{1'b1}} << s1_sh_r);

  logic [99:0]        s2_cal_r;
  logic [47:0]        s2_mp_r;
  logic signed [10:0] s2_fe_r;
  logic               s2_sub_r, s2_sp_r, s2_sc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cal_r <= {cal[99:1], cal[0] | (|lost)};
      s2_mp_r  <= s1_mp_r;
      s2_fe_r  <= s1_fe_r;
      s2_sub_r <= s1_sub_r;
      s2_sp_r  <= s1_sp_r;
      s2_sc_r  <= s1_sc_r;
    end
  end

  // stage 3: add or subtract magnitudes
  logic [99:0]  pf, sum, mag_nxt;
  logic [100:0] d1, d2;
  logic         sg_nxt;

  assign pf  = {50'b0, s2_mp_r, 2'b0};
  assign sum = pf + s2_cal_r;
  assign d1  = {1'b0, pf} - {1'b0, s2_cal_r};
  assign d2  = {1'b0, s2_cal_r} - {1'b0, pf};

  always_comb begin
    if (!s2_sub_r) begin
      mag_nxt = sum;
      sg_nxt  = s2_sp_r;
    end else if (!d1[100]) begin
      mag_nxt = d1[99:0];
      sg_nxt  = s2_sp_r;
    end else begin
      mag_nxt = d2[99:0];
      sg_nxt  = s2_sc_r;
    end
  end

  logic [99:0]        s3_mag_r;
  logic signed [10:0] s3_fe_r;
  logic               s3_sg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag_r <= mag_nxt;
      s3_fe_r  <= s2_fe_r;
      s3_sg_r  <= sg_nxt;
    end
  end

  // stage 4: leading zeros per byte group
  logic [103:0] mag104;
  logic [12:0]  gnz_nxt;
  logic [2:0]   glz_nxt [13];

  assign mag104 = {s3_mag_r, 4'b0};

  always_comb begin
    for (int g = 0; g < 13; g++) begin
      gnz_nxt[g] = |mag104[103-8*g -: 8];
      glz_nxt[g] = lz8(mag104[103-8*g -: 8]);
    end
  end

  logic [99:0]        s4_mag_r;
  logic [12:0]        s4_gnz_r;
  logic [2:0]         s4_glz_r [13];
  logic signed [10:0] s4_fe_r;
  logic               s4_sg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mag_r <= s3_mag_r;
      s4_gnz_r <= gnz_nxt;
      s4_glz_r <= glz_nxt;
      s4_fe_r  <= s3_fe_r;
      s4_sg_r  <= s3_sg_r;
    end
  end

  // stage 5: pick first group, exponent and normalising shift
  logic [6:0]         lz;
  logic signed [11:0] enorm, tsh;
  logic [6:0]         shl_nxt;
  logic [7:0]         e_nxt;

  always_comb begin
    lz = 7'd104;
    for (int g = 12; g >= 0; g--) begin
      if (s4_gnz_r[g]) lz = 7'(g * 8) + {4'b0, s4_glz_r[g]};
    end
  end

  assign enorm = $signed({s4_fe_r[10], s4_fe_r}) + 12'sd226 - $signed({5'b0, lz});
  assign tsh   = $signed({5'b0, lz}) + enorm - 12'sd1;

  always_comb begin
    if (enorm >= 12'sd1) begin
      shl_nxt = lz;
      e_nxt   = enorm[7:0];
    end else begin
      shl_nxt = (tsh < 12'sd0) ? 7'd0 : tsh[6:0];
      e_nxt   = 8'd0;
    end
  end

  logic [99:0] s5_mag_r;
  logic [6:0]  s5_shl_r;
  logic [7:0]  s5_e_r;
  logic        s5_sg_r, s5_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_mag_r  <= s4_mag_r;
      s5_shl_r  <= shl_nxt;
      s5_e_r    <= e_nxt;
      s5_sg_r   <= s4_sg_r;
      s5_zero_r <= ~|s4_gnz_r;
    end
  end

  // stage 6: normalise
  logic [99:0] nm;
  assign nm = s5_mag_r << s5_shl_r;

  logic [23:0] s6_m_r;
  logic        s6_g_r, s6_st_r, s6_sg_r, s6_zero_r;
  logic [7:0]  s6_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_m_r    <= nm[99:76];
      s6_g_r    <= nm[75];
      s6_st_r   <= |nm[74:0];
      s6_e_r    <= s5_e_r;
      s6_sg_r   <= s5_sg_r;
      s6_zero_r <= s5_zero_r;
    end
  end

  // stage 7: round to nearest even, carry runs into the exponent
  logic        inc;
  logic [30:0] rnd;
  assign inc = s6_g_r & (s6_st_r | s6_m_r[0]);
  assign rnd = {s6_e_r, s6_m_r[22:0]} + {30'b0, inc};

  logic [31:0] s7_y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_y_r <= s6_zero_r ? 32'd0 : {s6_sg_r, rnd};
    end
  end

  assign vld_o  = vld_r[DEPTH-1];
  assign side_o = side_r[DEPTH-1];
  assign y_o    = s7_y_r;

endmodule

// File: rtl/float32_exponential_unit.sv
`timescale 1ns / 1ps
// channel   | handshake           | payload
// input     | in_valid / in_stall | in_x_bits[31:0], in_last
// output    | out_valid/out_stall | out_y_bits[31:0], out_last
//
// One transaction per cycle unless the output stalls; each result passes through
// nine chained seven-stage fused multiply-add units plus the input,
// conversion and scaling registers.
// Reset (rst_n low, synchronous) clears the valid bits only.
// A stalled output register freezes every stage and raises in_stall.
module float32_exponential_unit import f32exp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_bits,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_y_bits,
  output logic        out_last
);

`include "assert_macros.svh"

  logic pipe_en;
  logic out_valid_r;
  logic [31:0] out_y_r;
  logic out_last_r;

  assign pipe_en  = !(out_valid_r && out_stall);
  assign in_stall = !pipe_en;

  // input register and classification
  logic        v0_r;
  logic [31:0] x0_r;
  logic        l0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (pipe_en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      x0_r <= in_x_bits;
      l0_r <= in_last;
    end
  end

  side_t s0;
  always_comb begin
    s0        = '0;
    s0.last   = l0_r;
    s0.x      = x0_r;
    s0.spec   = 1'b1;
    if (x0_r[30:0] > INF_MAG[30:0]) begin
      s0.spec_y = QNAN_BITS;
    end else if (!x0_r[31] && (x0_r[30:0] > EXP_HI_BITS[30:0])) begin
      s0.spec_y = PINF_BITS;
    end else if (x0_r[31] && (x0_r[30:0] > EXP_LO_BITS[30:0])) begin
      s0.spec_y = 32'd0;
    end else begin
      s0.spec   = 1'b0;
      s0.spec_y = 32'd0;
    end
  end

  // n = round(x * log2e)
  logic        v1;
  logic [31:0] y1;
  side_t       s1;

  f32exp_fma u_fma_scale (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .vld_i(v0_r),
    .a_i(x0_r), .b_i(LOG2E_BITS), .c_i(MAGIC_BITS), .side_i(s0),
    .vld_o(v1), .y_o(y1), .side_o(s1)
  );

  logic [30:0] n_raw;
  assign n_raw = y1[30:0] - MAGIC_BITS[30:0];

  logic  vn1_r;
  side_t sn1_r;
  side_t sn1_nxt;

  always_comb begin
    sn1_nxt   = s1;
    sn1_nxt.n = $signed(n_raw[8:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn1_r <= 1'b0;
    end else if (pipe_en) begin
      vn1_r <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sn1_r <= sn1_nxt;
    end
  end

  // n to binary32
  logic [8:0]  nmag;
  logic [3:0]  npos;
  logic [31:0] nsh;
  logic [31:0] nf_nxt;

  assign nmag = sn1_r.n[8] ? 9'(-sn1_r.n) : sn1_r.n;

  always_comb begin
    npos = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (nmag[i]) npos = 4'(i);
    end
  end

  assign nsh    = {nmag, 23'b0} >> npos;
  assign nf_nxt = (nmag == 9'd0) ? 32'd0
                : {sn1_r.n[8], 8'd127 + {4'b0, npos}, nsh[22:0]};

  logic  vn2_r;
  side_t sn2_r;
  side_t sn2_nxt;

  always_comb begin
    sn2_nxt    = sn1_r;
    sn2_nxt.nf = nf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn2_r <= 1'b0;
    end else if (pipe_en) begin
      vn2_r <= vn1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sn2_r <= sn2_nxt;
    end
  end

  // two-part reduction
  logic        v2, v3;
  logic [31:0] y2, y3;
  side_t       s2, s3, s3r;

  f32exp_fma u_fma_red_hi (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .vld_i(vn2_r),
    .a_i(sn2_r.nf), .b_i(LN2_HI_BITS), .c_i(sn2_r.x), .side_i(sn2_r),
    .vld_o(v2), .y_o(y2), .side_o(s2)
  );

  f32exp_fma u_fma_red_lo (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .vld_i(v2),
    .a_i(s2.nf), .b_i(LN2_LO_BITS), .c_i(y2), .side_i(s2),
    .vld_o(v3), .y_o(y3), .side_o(s3)
  );

  always_comb begin
    s3r   = s3;
    s3r.r = y3;
  end

  // Horner chain
  logic        pv [NUM_POLY];
  logic [31:0] py [NUM_POLY];
  side_t       ps [NUM_POLY];

  for (genvar k = 0; k < NUM_POLY; k++) begin : g_poly
    if (k == 0) begin : g_first
      f32exp_fma u_fma (
        .clk(clk), .rst_n(rst_n), .en(pipe_en), .vld_i(v3),
        .a_i(PC0_BITS), .b_i(y3), .c_i(POLY_C[k]), .side_i(s3r),
        .vld_o(pv[k]), .y_o(py[k]), .side_o(ps[k])
      );
    end else begin : g_next
      f32exp_fma u_fma (
        .clk(clk), .rst_n(rst_n), .en(pipe_en), .vld_i(pv[k-1]),
        .a_i(py[k-1]), .b_i(ps[k-1].r), .c_i(POLY_C[k]), .side_i(ps[k-1]),
        .vld_o(pv[k]), .y_o(py[k]), .side_o(ps[k])
      );
    end
  end

  // scale by 2^n
  logic [31:0]        poly;
  side_t              pside;
  logic signed [10:0] es;
  logic signed [10:0] shs;
  logic [4:0]         sh_nxt;

  assign poly  = py[NUM_POLY-1];
  assign pside = ps[NUM_POLY-1];
  assign es    = $signed({3'b0, poly[30:23]}) + $signed({{2{pside.n[8]}}, pside.n});
  assign shs   = 11'sd1 - es;
  assign sh_nxt = (shs > 11'sd31) ? 5'd31 : shs[4:0];

  logic        sa_vld_r;
  side_t       sa_side_r;
  logic        sa_ovf_r, sa_norm_r;
  logic [7:0]  sa_e_r;
  logic [23:0] sa_m_r;
  logic [4:0]  sa_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else if (pipe_en) begin
      sa_vld_r <= pv[NUM_POLY-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sa_side_r <= pside;
      sa_ovf_r  <= es > 11'sd254;
      sa_norm_r <= es >= 11'sd1;
      sa_e_r    <= es[7:0];
      sa_m_r    <= {1'b1, poly[22:0]};
      sa_sh_r   <= sh_nxt;
    end
  end

  logic [4:0]  shm1;
  logic [23:0] mm, gsh;
  logic        sinc, sstk;
  logic [30:0] sub_rnd;
  logic [31:0] y_nxt;

  assign shm1    = sa_sh_r - 5'd1;
  assign mm      = sa_m_r >> sa_sh_r;
  assign gsh     = sa_m_r >> shm1;
  assign sstk    = |(sa_m_r & ~(24'hFFFFFF << shm1));
  assign sinc    = gsh[0] & (sstk | mm[0]);
  assign sub_rnd = {8'd0, mm[22:0]} + {30'b0, sinc};

  always_comb begin
    priority if (sa_side_r.spec) begin
      y_nxt = sa_side_r.spec_y;
    end else if (sa_ovf_r) begin
      y_nxt = PINF_BITS;
    end else if (sa_norm_r) begin
      y_nxt = {1'b0, sa_e_r, sa_m_r[22:0]};
    end else begin
      y_nxt = {1'b0, sub_rnd};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= sa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_y_r    <= y_nxt;
      out_last_r <= sa_side_r.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_y_bits = out_y_r;
  assign out_last   = out_last_r;

  logic y_top_exp, y_frac_ok;
  assign y_top_exp = out_y_bits[30:23] == 8'hFF;
  assign y_frac_ok = (out_y_bits[22:0] == 23'h0) || (out_y_bits[22:0] == 23'h400000);

  `ASSERT_NEVER(a_sign_clear, clk, rst_n, out_valid && out_y_bits[31])
  `ASSERT_PROP(a_nan_canon, clk, rst_n, (out_valid && y_top_exp) |-> y_frac_ok)
  `ASSERT_PROP(a_freeze, clk, rst_n, !pipe_en |=> $stable(v0_r))

endmodule

// File: tb/exp_result_checker.sv
`timescale 1ns / 1ps
module exp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_x_bits,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_y_bits,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  import f32exp_pkg::*;

  logic [31:0] exp_y_q[$];
  logic        exp_last_q[$];

  function automatic real f32_to_real(input logic [31:0] f);
    real v;
    if (f[30:23] == 8'd0) begin
      v = real'(f[22:0]) * (2.0 ** -149);
      if (f[31]) v = -v;
    end else begin
      v = $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0});
    end
    return v;
  endfunction

  // double to binary32, nearest-even, subnormals and overflow included
  function automatic logic [31:0] real_to_f32(input real d);
    logic [63:0] b;
    logic [63:0] sig, kept, rem, half;
    int e, sh;
    logic up;
    b = $realtobits(d);
    if (b[62:0] == 63'd0) return {b[63], 31'd0};
    e = int'(b[62:52]) - 1023;
    sig = {11'd0, 1'b1, b[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) return {b[63], 31'd0};
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    up = (rem > half) || (rem == half && kept[0]);
    kept = kept + 64'(up);
    if (e >= -126) begin
      if (kept == 64'd1 << 24) begin
        kept = 64'd1 << 23;
        e = e + 1;
      end
      if (e + 127 >= 255) return {b[63], PINF_BITS[30:0]};
      return {b[63], 8'(e + 127), kept[22:0]};
    end
    return {b[63], kept[30:0]};
  endfunction

  // a*b+c, single rounding via round-to-odd in double
  function automatic logic [31:0] fma32(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    real p, cd, s, bb, err;
    logic [63:0] sb;
    p = f32_to_real(a) * f32_to_real(b);
    cd = f32_to_real(c);
    s = p + cd;
    bb = s - p;
    err = (p - (s - bb)) + (cd - bb);
    if (err != 0.0) begin
      sb = $realtobits(s);
      if (!sb[0]) begin
        if ((err > 0.0) == (s > 0.0)) sb = sb + 64'd1;
        else sb = sb - 64'd1;
      end
      s = $bitstoreal(sb);
    end
    return real_to_f32(s);
  endfunction

  function automatic logic [31:0] predict_exp(input logic [31:0] xb);
    real x, poly_d, d, edge_v;
    logic [31:0] sc, nf, r, poly;
    int n;
    x = f32_to_real(xb);
    edge_v = $bitstoreal({1'b0, 11'd1150, 52'hFFFFFF0000000});
    if (xb[30:0] > INF_MAG[30:0]) return QNAN_BITS;
    if (x > f32_to_real(EXP_HI_BITS)) return PINF_BITS;
    if (x < f32_to_real(EXP_LO_BITS)) return 32'd0;
    sc = fma32(xb, LOG2E_BITS, MAGIC_BITS);
    n = int'({1'b0, sc[30:0]}) - int'(MAGIC_BITS);
    if (n < -1000) n = -1000;
    if (n > 1000) n = 1000;
    nf = real_to_f32(real'(n));
    r = fma32(nf, LN2_HI_BITS, xb);
    r = fma32(nf, LN2_LO_BITS, r);
    poly = PC0_BITS;
    for (int i = 0; i < NUM_POLY; i++) poly = fma32(poly, r, POLY_C[i]);
    poly_d = f32_to_real(poly);
    d = poly_d * $bitstoreal({1'b0, 11'(n + 1023), 52'd0});
    if (d >= edge_v) return PINF_BITS;
    if (d <= -edge_v) return {1'b1, INF_MAG[30:0]};
    return real_to_f32(d);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count = fail_count + 1;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic [31:0] wy;
    logic wl;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (exp_y_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_y_bits, 32'd0);
        end else begin
          wy = exp_y_q.pop_front();
          wl = exp_last_q.pop_front();
          if (out_y_bits !== wy) report_mismatch("y_bits", out_y_bits, wy);
          if (out_last !== wl) report_mismatch("last", 32'(out_last), 32'(wl));
        end
      end
      if (in_valid && !in_stall) begin
        exp_y_q.push_back(predict_exp(in_x_bits));
        exp_last_q.push_back(in_last);
      end
      pending = exp_y_q.size();
    end
  end
endmodule

// File: tb/tb_float32_exponential_unit.sv
`timescale 1ns / 1ps
module tb_float32_exponential_unit;
  import f32exp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_x_bits;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_y_bits;
  logic        out_last;
  int          fail_count;
  int          pending;
  bit          quiet;

  float32_exponential_unit u_dut (.*);

  exp_result_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_x_bits, .in_last,
    .out_valid, .out_stall, .out_y_bits, .out_last, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_operand(input logic [31:0] x, input logic last);
    logic stalled;
    in_valid <= 1'b1;
    in_x_bits <= x;
    in_last <= last;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3: v[30:23] = 8'd133;
      4: v[30:23] = 8'($urandom_range(0, 8));
      default: v[30:23] = 8'($urandom_range(90, 133));
    endcase
    return v;
  endfunction

  logic [31:0] directed[] = '{
    32'h7FC00000, 32'hFFFFFFFF, 32'h7F800001, 32'h7F800000, 32'hFF800000,
    32'h00000000, 32'h80000000, 32'h00000001, 32'h807FFFFF, 32'h3F800000,
    32'hBF800000, EXP_HI_BITS, EXP_HI_BITS + 1, EXP_HI_BITS - 1, EXP_LO_BITS,
    EXP_LO_BITS + 1, EXP_LO_BITS - 1, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h42B17218,
    32'hC2AEAC50, 32'hC2B00000, 32'hC2CE0000, 32'h3F317218, 32'h33800000
  };

  initial begin
    int total;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_bits = '0;
    in_last = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_operand(directed[i], i[0]);
    total = 1850;
    for (int i = 0; i < total; i++) begin
      if (i == total - 300) quiet = 1'b1;
      send_operand(random_operand(), $urandom_range(0, 1));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
